@@ rtl/far_pkg.sv @@
// ----------------------------------------------------------------------------
// far_pkg
// Shared types and codes for the fraction arithmetic block.
// ----------------------------------------------------------------------------
package far_pkg;

  // Operation codes.
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_MUL = 2'd1;
  localparam logic [1:0] CMD_DIV = 2'd2;
  localparam logic [1:0] CMD_BAD = 2'd3;

  // Internal working width and result width.
  localparam int WORK_W = 64;
  localparam int RES_W  = 33;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_GCD  = 7'b0000010,
    ST_FAC  = 7'b0000100,
    ST_MUL  = 7'b0001000,
    ST_PRE  = 7'b0010000,
    ST_RED  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

endpackage

@@ rtl/far_if.sv @@
// ----------------------------------------------------------------------------
// far_in_if / far_out_if / far_cfg_if
// Valid-ready channels of the fraction arithmetic block.
// ----------------------------------------------------------------------------
interface far_in_if #(parameter int W = 16);
  logic         valid;
  logic         ready;
  logic [1:0]   cmd;
  logic [W-1:0] num_a;
  logic [W-1:0] den_a;
  logic [W-1:0] num_b;
  logic [W-1:0] den_b;
  modport source (output valid, cmd, num_a, den_a, num_b, den_b, input ready);
  modport sink   (input valid, cmd, num_a, den_a, num_b, den_b, output ready);
endinterface

interface far_out_if;
  logic        valid;
  logic        ready;
  logic [32:0] res_num;
  logic [32:0] res_den;
  logic        error;
  modport source (output valid, res_num, res_den, error, input ready);
  modport sink   (input valid, res_num, res_den, error, output ready);
endinterface

interface far_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ rtl/far_divu.sv @@
// ----------------------------------------------------------------------------
// far_divu
// Bit-serial unsigned divider: one quotient bit per cycle over 64 bits.
// ----------------------------------------------------------------------------
module far_divu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quot,
  output logic [63:0] rem
);

  logic [63:0] q_r, q_nxt;
  logic [63:0] r_r, r_nxt;
  logic [63:0] d_r, d_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [64:0] trial;

  // Restoring step: shift one dividend bit into the remainder.
  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {r_r, q_r[63]} - {1'b0, d_r};
    if (start) begin
      q_nxt    = dividend;
      r_nxt    = '0;
      d_nxt    = divisor;
      cnt_nxt  = 7'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial[64]) begin
        r_nxt = {r_r[62:0], q_r[63]};
        q_nxt = {q_r[62:0], 1'b0};
      end else begin
        r_nxt = trial[63:0];
        q_nxt = {q_r[62:0], 1'b1};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;

endmodule

@@ rtl/far_mulu.sv @@
// ----------------------------------------------------------------------------
// far_mulu
// Shift-and-add multiplier: one multiplier bit per cycle, 64-bit wrapping.
// ----------------------------------------------------------------------------
module far_mulu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] prod
);

  logic [63:0] acc_r, acc_nxt;
  logic [63:0] a_r, a_nxt;
  logic [63:0] b_r, b_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;

  // Each step adds the shifted multiplicand when the low bit is set.
  always_comb begin
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      a_nxt    = a;
      b_nxt    = b;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (b_r[0]) acc_nxt = acc_r + a_r;
        a_nxt = {a_r[62:0], 1'b0};
        b_nxt = {1'b0, b_r[63:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

@@ rtl/fraction_arith_reduce.sv @@
// ----------------------------------------------------------------------------
// fraction_arith_reduce
// Signed fraction add, multiply and divide with gcd reduction.
// ----------------------------------------------------------------------------
// An error beat or an unreduced equal-denominator sum is offered the cycle after
// its input beat. Otherwise the result waits on serial divider and multiplier
// runs: the gcd loop steps, the scale factors, the products and the reduction.
// Throughput: one item at a time; in_ch.ready returns the cycle after the result beat.
// Reset (rst_n low, synchronous) returns to idle and sets red_r, the sum reduction enable, to 1.
module fraction_arith_reduce #(
  parameter int OPERAND_WIDTH = 16
) (
  input logic clk,
  input logic rst_n,
  far_in_if.sink    in_ch,
  far_out_if.source out_ch,
  far_cfg_if.sink   cfg_ch
);

  localparam int W  = OPERAND_WIDTH;
  localparam int XW = far_pkg::WORK_W;

  far_pkg::state_t st_r, st_nxt;

  logic [1:0]    ph_r, ph_nxt;
  logic          run_r, run_nxt;
  logic          red_r, red_nxt;
  logic          err_r, err_nxt;
  logic          lcm_r, lcm_nxt;
  logic [1:0]    cmd_r, cmd_nxt;
  logic [XW-1:0] na_r, na_nxt, da_r, da_nxt, nb_r, nb_nxt, db_r, db_nxt;
  logic [XW-1:0] ga_r, ga_nxt, gb_r, gb_nxt;
  logic [XW-1:0] fa_r, fa_nxt, fb_r, fb_nxt;
  logic [XW-1:0] rn_r, rn_nxt, rd_r, rd_nxt;

  // Sign-extended operands.
  logic [XW-1:0] na_s, da_s, nb_s, db_s;
  assign na_s = {{(XW-W){in_ch.num_a[W-1]}}, in_ch.num_a};
  assign da_s = {{(XW-W){in_ch.den_a[W-1]}}, in_ch.den_a};
  assign nb_s = {{(XW-W){in_ch.num_b[W-1]}}, in_ch.num_b};
  assign db_s = {{(XW-W){in_ch.den_b[W-1]}}, in_ch.den_b};

  function automatic logic [63:0] mag(input logic [63:0] v);
    mag = v[63] ? (64'd0 - v) : v;
  endfunction

  // Shared serial units.
  logic          m_start, m_done;
  logic [XW-1:0] m_a, m_b, m_p;
  logic          d_start, d_done;
  logic [XW-1:0] d_n, d_d, d_q, d_rm;

  far_mulu u_mul (.clk, .rst_n, .start(m_start), .a(m_a), .b(m_b),
                  .done(m_done), .prod(m_p));
  far_divu u_div (.clk, .rst_n, .start(d_start), .dividend(d_n), .divisor(d_d),
                  .done(d_done), .quot(d_q), .rem(d_rm));

  logic accept;
  logic bad_in;
  logic mul_first;
  assign in_ch.ready  = st_r == far_pkg::ST_IDLE;
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign mul_first    = ph_r == 2'd0;
  assign bad_in       = (da_s == '0) || (db_s == '0) || (in_ch.cmd == far_pkg::CMD_BAD) ||
                        ((in_ch.cmd == far_pkg::CMD_DIV) && (nb_s == '0));

  // Sequencer: one unit operation at a time, started when nothing is running
  // and its result taken on the done pulse.
  always_comb begin
    st_nxt  = st_r;
    ph_nxt  = ph_r;
    run_nxt = run_r;
    red_nxt = cfg_ch.valid ? cfg_ch.data : red_r;
    err_nxt = err_r;
    lcm_nxt = lcm_r;
    cmd_nxt = cmd_r;
    na_nxt  = na_r; da_nxt = da_r; nb_nxt = nb_r; db_nxt = db_r;
    ga_nxt  = ga_r; gb_nxt = gb_r;
    fa_nxt  = fa_r; fb_nxt = fb_r;
    rn_nxt  = rn_r; rd_nxt = rd_r;
    m_start = 1'b0; m_a = '0; m_b = '0;
    d_start = 1'b0; d_n = '0; d_d = 64'd1;
    case (st_r)
      far_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_nxt = in_ch.cmd;
          na_nxt  = na_s; da_nxt = da_s; nb_nxt = nb_s; db_nxt = db_s;
          err_nxt = bad_in;
          ph_nxt  = '0;
          if (bad_in) begin
            rn_nxt = '0;
            rd_nxt = 64'd1;
            st_nxt = far_pkg::ST_OUT;
          end else if (in_ch.cmd == far_pkg::CMD_ADD) begin
            if (da_s == db_s) begin
              rn_nxt = na_s + nb_s;
              rd_nxt = da_s;
              st_nxt = red_r ? far_pkg::ST_PRE : far_pkg::ST_OUT;
            end else begin
              ga_nxt  = mag(da_s);
              gb_nxt  = mag(db_s);
              lcm_nxt = 1'b1;
              st_nxt  = far_pkg::ST_GCD;
            end
          end else begin
            st_nxt = far_pkg::ST_MUL;
          end
        end
      end
      // Euclid loop: one division per step, remainder becomes the new divisor.
      far_pkg::ST_GCD: begin
        if (!run_r) begin
          if (gb_r == '0) begin
            ph_nxt = '0;
            if (lcm_r) begin
              st_nxt = far_pkg::ST_FAC;
            end else begin
              st_nxt = far_pkg::ST_RED;
              if (ga_r == '0) ga_nxt = 64'd1;
            end
          end else begin
            d_start = 1'b1; d_n = ga_r; d_d = gb_r;
            run_nxt = 1'b1;
          end
        end else if (d_done) begin
          ga_nxt  = gb_r;
          gb_nxt  = d_rm;
          run_nxt = 1'b0;
        end
      end
      // Common denominator: the two scale factors, then the lcm.
      far_pkg::ST_FAC: begin
        if (!run_r) begin
          run_nxt = 1'b1;
          case (ph_r)
            2'd0: begin
              d_start = 1'b1; d_n = mag(db_r); d_d = ga_r;
            end
            2'd1: begin
              d_start = 1'b1; d_n = mag(da_r); d_d = ga_r;
            end
            default: begin
              m_start = 1'b1; m_a = rd_r; m_b = mag(db_r);
            end
          endcase
        end else if (m_done || d_done) begin
          run_nxt = 1'b0;
          ph_nxt  = ph_r + 2'd1;
          case (ph_r)
            2'd0: fa_nxt = da_r[63] ? 64'd0 - d_q : d_q;
            2'd1: begin
              fb_nxt = db_r[63] ? 64'd0 - d_q : d_q;
              rd_nxt = d_q;
            end
            default: begin
              rd_nxt = m_p;
              ph_nxt = '0;
              st_nxt = far_pkg::ST_MUL;
            end
          endcase
        end
      end
      // Two products: numerator first, then denominator or second term.
      far_pkg::ST_MUL: begin
        if (!run_r) begin
          m_start = 1'b1;
          run_nxt = 1'b1;
          case (cmd_r)
            far_pkg::CMD_ADD: begin
              m_a = mul_first ? na_r : nb_r;
              m_b = mul_first ? fa_r : fb_r;
            end
            far_pkg::CMD_MUL: begin
              m_a = mul_first ? na_r : da_r;
              m_b = mul_first ? nb_r : db_r;
            end
            default: begin
              m_a = mul_first ? na_r : da_r;
              m_b = mul_first ? db_r : nb_r;
            end
          endcase
        end else if (m_done) begin
          run_nxt = 1'b0;
          if (mul_first) begin
            rn_nxt = m_p;
            ph_nxt = 2'd1;
          end else begin
            ph_nxt = '0;
            if (cmd_r == far_pkg::CMD_ADD) begin
              rn_nxt = rn_r + m_p;
              st_nxt = red_r ? far_pkg::ST_PRE : far_pkg::ST_OUT;
            end else begin
              rd_nxt = m_p;
              st_nxt = far_pkg::ST_PRE;
            end
          end
        end
      end
      // Set up the gcd of the result magnitudes.
      far_pkg::ST_PRE: begin
        ga_nxt  = mag(rn_r);
        gb_nxt  = mag(rd_r);
        lcm_nxt = 1'b0;
        st_nxt  = far_pkg::ST_GCD;
      end
      // Divide both parts by the gcd, keeping each sign.
      far_pkg::ST_RED: begin
        if (!run_r) begin
          d_start = 1'b1;
          run_nxt = 1'b1;
          d_n     = mul_first ? mag(rn_r) : mag(rd_r);
          d_d     = ga_r;
        end else if (d_done) begin
          run_nxt = 1'b0;
          if (mul_first) begin
            rn_nxt = rn_r[63] ? 64'd0 - d_q : d_q;
            ph_nxt = 2'd1;
          end else begin
            rd_nxt = rd_r[63] ? 64'd0 - d_q : d_q;
            ph_nxt = '0;
            st_nxt = far_pkg::ST_OUT;
          end
        end
      end
      far_pkg::ST_OUT: begin
        if (out_ch.ready) st_nxt = far_pkg::ST_IDLE;
      end
      default: st_nxt = far_pkg::ST_IDLE;
    endcase
  end

  // Control registers are reset; the datapath is loaded before use.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= far_pkg::ST_IDLE;
      ph_r  <= '0;
      run_r <= 1'b0;
      red_r <= 1'b1;
      err_r <= 1'b0;
      lcm_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      ph_r  <= ph_nxt;
      run_r <= run_nxt;
      red_r <= red_nxt;
      err_r <= err_nxt;
      lcm_r <= lcm_nxt;
    end
    cmd_r <= cmd_nxt;
    na_r  <= na_nxt;
    da_r  <= da_nxt;
    nb_r  <= nb_nxt;
    db_r  <= db_nxt;
    ga_r  <= ga_nxt;
    gb_r  <= gb_nxt;
    fa_r  <= fa_nxt;
    fb_r  <= fb_nxt;
    rn_r  <= rn_nxt;
    rd_r  <= rd_nxt;
  end

  // Result beat.
  assign out_ch.valid   = st_r == far_pkg::ST_OUT;
  assign out_ch.res_num = rn_r[far_pkg::RES_W-1:0];
  assign out_ch.res_den = rd_r[far_pkg::RES_W-1:0];
  assign out_ch.error   = err_r;

endmodule
